// File: design/fes_pkg.sv
package fes_pkg;

	// field widths
	localparam int unsigned PRESS_W  = 17;
	localparam int unsigned LIGHT_W  = 10;
	localparam int unsigned MARGIN_W = 12;
	localparam int unsigned PRESS_MAX = 131071;

	// default structure of the block
	localparam int unsigned PRESSURE_TAPS_DEF = 30;
	localparam int unsigned LIGHT_TAPS_DEF    = 30;
	localparam int unsigned STREAK_NEEDED_DEF = 3;

	// register reset values
	localparam logic [PRESS_W-1:0]  GROUND_RST  = 17'd101325;
	localparam logic [PRESS_W-1:0]  LIFTOFF_RST = 17'd100725;
	localparam logic [MARGIN_W-1:0] APOGEE_RST  = 12'd12;
	localparam logic [PRESS_W-1:0]  TETHER_RST  = 17'd98945;
	localparam logic [PRESS_W-1:0]  CHUTE_RST   = 17'd100129;
	localparam logic [LIGHT_W-1:0]  LBASE_RST   = 10'd0;
	localparam logic [LIGHT_W-1:0]  LMARGIN_RST = 10'd155;

	// apb register map, word index
	localparam int unsigned DATA_W = 32;
	localparam int unsigned ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_GROUND  = 3'd0,
		REG_LIFTOFF = 3'd1,
		REG_APOGEE  = 3'd2,
		REG_TETHER  = 3'd3,
		REG_CHUTE   = 3'd4,
		REG_LBASE   = 3'd5,
		REG_LMARGIN = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [PRESS_W-1:0]  ground_pressure;
		logic [PRESS_W-1:0]  liftoff_pressure;
		logic [MARGIN_W-1:0] apogee_margin;
		logic [PRESS_W-1:0]  tether_pressure;
		logic [PRESS_W-1:0]  chute_pressure;
		logic [LIGHT_W-1:0]  light_base;
		logic [LIGHT_W-1:0]  light_margin;
	} cfg_t;

	typedef struct packed {
		logic               pressure_valid;
		logic [PRESS_W-1:0] pressure_pa;
		logic [LIGHT_W-1:0] light_raw;
	} sample_t;

	typedef struct packed {
		logic [PRESS_W-1:0] average_pressure;
		logic               liftoff_seen;
		logic               apogee_seen;
		logic               nose_cone_seen;
		logic               camera_start;
		logic               tether_fire;
		logic               chute_fire;
	} result_t;

endpackage

// File: design/fes_cell.sv
module fes_cell #(
	parameter int unsigned W = 17,
	parameter int unsigned RESET_VAL = 0
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         shift,
	input  logic         load,
	input  logic [W-1:0] load_val,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= W'(RESET_VAL);
		end else if (load) begin
			val_q <= load_val;
		end else if (shift) begin
			val_q <= d;
		end
	end

	assign q = val_q;

endmodule

// File: design/fes_window.sv
module fes_window #(
	parameter int unsigned W = 17,
	parameter int unsigned TAPS = 30,
	parameter int unsigned TOT_W = 22,
	parameter int unsigned RESET_VAL = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift,
	input  logic [W-1:0]     din,
	input  logic             load,
	input  logic [W-1:0]     load_val,
	output logic [TOT_W-1:0] total_next
);

	logic [W-1:0]     tap [TAPS];
	logic [TOT_W-1:0] total_q;

	// row of cells, newest sample enters at cell zero, oldest leaves the far end
	for (genvar i = 0; i < TAPS; i++) begin : g_cell
		logic [W-1:0] d_in;
		if (i == 0) begin : g_head
			assign d_in = din;
		end else begin : g_link
			assign d_in = tap[i-1];
		end
		fes_cell #(
			.W(W),
			.RESET_VAL(RESET_VAL)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (shift),
			.load    (load),
			.load_val(load_val),
			.d       (d_in),
			.q       (tap[i])
		);
	end

	always_comb begin
		total_next = total_q;
		if (shift) begin
			total_next = total_q - TOT_W'(tap[TAPS-1]) + TOT_W'(din);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TOT_W'(TAPS * RESET_VAL);
		end else if (load) begin
			total_q <= TOT_W'(load_val) * TOT_W'(TAPS);
		end else begin
			total_q <= total_next;
		end
	end

endmodule

// File: design/fes_events.sv
module fes_events #(
	parameter int unsigned STREAK_NEEDED = 3,
	parameter int unsigned LCMP_W = 18
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic                        pv,
	input  logic [fes_pkg::PRESS_W-1:0] avg,
	input  logic [LCMP_W-1:0]           light_total,
	input  logic [LCMP_W-1:0]           light_thr,
	input  fes_pkg::cfg_t               cfg,
	output fes_pkg::result_t            res
);

	logic [fes_pkg::PRESS_W-1:0] lowest_q, lowest_n;
	logic [1:0]                  streak_q, streak_n;
	logic liftoff_q, apogee_q, nose_q, tether_q, chute_q;
	logic liftoff_n, apogee_n, nose_n, tether_n, chute_n;
	logic nose_hit, tether_hit, chute_hit;
	logic [fes_pkg::PRESS_W:0]   apogee_lim;

	always_comb begin
		lowest_n  = lowest_q;
		streak_n  = streak_q;
		liftoff_n = liftoff_q;
		if (pv) begin
			if (avg < lowest_q) begin
				lowest_n = avg;
			end
			if (!liftoff_q) begin
				if (avg < cfg.liftoff_pressure) begin
					streak_n  = (streak_q == 2'd3) ? streak_q : streak_q + 2'd1;
					liftoff_n = (streak_n >= 2'(STREAK_NEEDED));
				end else begin
					streak_n = 2'd0;
				end
			end
		end

		// full width, no wrap near the top of range
		apogee_lim = {1'b0, lowest_n} + (fes_pkg::PRESS_W+1)'(cfg.apogee_margin);
		apogee_n   = apogee_q || (liftoff_n && ({1'b0, avg} > apogee_lim));

		nose_hit   = !nose_q && (light_total > light_thr);
		nose_n     = nose_q || nose_hit;
		tether_hit = !tether_q && (avg < cfg.tether_pressure);
		tether_n   = tether_q || tether_hit;
		chute_hit  = !chute_q && tether_n && (avg > cfg.chute_pressure);
		chute_n    = chute_q || chute_hit;

		res.average_pressure = avg;
		res.liftoff_seen     = liftoff_n;
		res.apogee_seen      = apogee_n;
		res.nose_cone_seen   = nose_n;
		res.camera_start     = nose_hit;
		res.tether_fire      = tether_hit;
		res.chute_fire       = chute_hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowest_q  <= fes_pkg::PRESS_W'(fes_pkg::PRESS_MAX);
			streak_q  <= 2'd0;
			liftoff_q <= 1'b0;
			apogee_q  <= 1'b0;
			nose_q    <= 1'b0;
			tether_q  <= 1'b0;
			chute_q   <= 1'b0;
		end else if (advance) begin
			lowest_q  <= lowest_n;
			streak_q  <= streak_n;
			liftoff_q <= liftoff_n;
			apogee_q  <= apogee_n;
			nose_q    <= nose_n;
			tether_q  <= tether_n;
			chute_q   <= chute_n;
		end
	end

`ifndef ASSERT_OFF
	a_apogee_after_liftoff: assert property (@(posedge clk) disable iff (!arst_n)
		apogee_q |-> liftoff_q)
		else $error("apogee flag without liftoff");

	a_chute_after_tether: assert property (@(posedge clk) disable iff (!arst_n)
		chute_q |-> tether_q)
		else $error("chute flag without tether release");

	a_tether_fires_once: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.tether_fire) |=> tether_q)
		else $error("tether strobe did not latch its flag");
`endif

endmodule

// File: design/flight_event_sequencer_core.sv
// channel  | valid         | stall         | payload                        | dir
// ---------+---------------+---------------+--------------------------------+----
// sample   | sample_valid  | sample_stall  | sample (pressure + light tick) | in
// result   | result_valid  | result_stall  | result (average, flags, fires) | out
// config   | psel/penable  | pready = 1    | paddr, pwdata, prdata          | in
//
// a tick passes from acceptance to result through window update, average
// multiply, event decision; one tick per cycle is accepted back to back unless stalled
// the average is a multiply by a reciprocal of the tap count, in a stage of its own
// reset restores the default registers, preloads every pressure cell with ground
// pressure and clears light cells and event flags; no clearing pass is needed
// a stalled result holds; the two inner stages keep filling until all three are full
module flight_event_sequencer_core #(
	parameter int unsigned PRESSURE_TAPS = fes_pkg::PRESSURE_TAPS_DEF,
	parameter int unsigned LIGHT_TAPS = fes_pkg::LIGHT_TAPS_DEF,
	parameter int unsigned LIFTOFF_STREAK_NEEDED = fes_pkg::STREAK_NEEDED_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// tick requests
	input  logic                       sample_valid,
	output logic                       sample_stall,
	input  fes_pkg::sample_t           sample,
	// result requests
	output logic                       result_valid,
	input  logic                       result_stall,
	output fes_pkg::result_t           result,
	// register port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fes_pkg::ADDR_W-1:0] paddr,
	input  logic [fes_pkg::DATA_W-1:0] pwdata,
	output logic [fes_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);

	localparam int unsigned PW = fes_pkg::PRESS_W;
	localparam int unsigned LW = fes_pkg::LIGHT_W;
	// running sum widths
	localparam int unsigned PTOT_W = $clog2(PRESSURE_TAPS * fes_pkg::PRESS_MAX + 1);
	localparam int unsigned LTOT_W = $clog2(LIGHT_TAPS * ((1 << LW) - 1) + 1);
	localparam int unsigned FILL_W = $clog2(LIGHT_TAPS + 1);
	// light compare: (base + margin) * fill and the total both fit here
	localparam int unsigned LCMP_W = LW + 1 + FILL_W;
	// floor(total / taps) = (total * RECIP) >> DIV_SH, exact for every total
	localparam int unsigned DIV_SH = PTOT_W + $clog2(PRESSURE_TAPS);
	localparam longint unsigned RECIP =
		((64'd1 << DIV_SH) + PRESSURE_TAPS - 1) / PRESSURE_TAPS;
	localparam int unsigned RECIP_W = PTOT_W + 1;
	localparam int unsigned PROD_W = PTOT_W + RECIP_W;

	// configuration registers
	fes_pkg::cfg_t     cfg_q;
	fes_pkg::reg_idx_t reg_idx;
	logic              cfg_wr;
	logic              ground_load;

	assign pready  = 1'b1;
	assign reg_idx = fes_pkg::reg_idx_t'(paddr[fes_pkg::ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign ground_load = cfg_wr && (reg_idx == fes_pkg::REG_GROUND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ground_pressure  <= fes_pkg::GROUND_RST;
			cfg_q.liftoff_pressure <= fes_pkg::LIFTOFF_RST;
			cfg_q.apogee_margin    <= fes_pkg::APOGEE_RST;
			cfg_q.tether_pressure  <= fes_pkg::TETHER_RST;
			cfg_q.chute_pressure   <= fes_pkg::CHUTE_RST;
			cfg_q.light_base       <= fes_pkg::LBASE_RST;
			cfg_q.light_margin     <= fes_pkg::LMARGIN_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				fes_pkg::REG_GROUND:  cfg_q.ground_pressure  <= pwdata[PW-1:0];
				fes_pkg::REG_LIFTOFF: cfg_q.liftoff_pressure <= pwdata[PW-1:0];
				fes_pkg::REG_APOGEE:  cfg_q.apogee_margin    <= pwdata[fes_pkg::MARGIN_W-1:0];
				fes_pkg::REG_TETHER:  cfg_q.tether_pressure  <= pwdata[PW-1:0];
				fes_pkg::REG_CHUTE:   cfg_q.chute_pressure   <= pwdata[PW-1:0];
				fes_pkg::REG_LBASE:   cfg_q.light_base       <= pwdata[LW-1:0];
				fes_pkg::REG_LMARGIN: cfg_q.light_margin     <= pwdata[LW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			fes_pkg::REG_GROUND:  prdata = fes_pkg::DATA_W'(cfg_q.ground_pressure);
			fes_pkg::REG_LIFTOFF: prdata = fes_pkg::DATA_W'(cfg_q.liftoff_pressure);
			fes_pkg::REG_APOGEE:  prdata = fes_pkg::DATA_W'(cfg_q.apogee_margin);
			fes_pkg::REG_TETHER:  prdata = fes_pkg::DATA_W'(cfg_q.tether_pressure);
			fes_pkg::REG_CHUTE:   prdata = fes_pkg::DATA_W'(cfg_q.chute_pressure);
			fes_pkg::REG_LBASE:   prdata = fes_pkg::DATA_W'(cfg_q.light_base);
			fes_pkg::REG_LMARGIN: prdata = fes_pkg::DATA_W'(cfg_q.light_margin);
			default:              prdata = '0;
		endcase
	end

	// pipeline control: each stage moves when the one after it is empty or moving
	logic v_s1, v_s2, result_valid_q;
	logic en1, en2, en3, accept;

	assign en3          = !result_valid_q || !result_stall;
	assign en2          = !v_s2 || en3;
	assign en1          = !v_s1 || en2;
	assign sample_stall = !en1;
	assign accept       = sample_valid && en1;

	// stage 1: windows shift, running sums update
	logic [PTOT_W-1:0] ptot_next;
	logic [LTOT_W-1:0] ltot_next;
	logic [FILL_W-1:0] fill_q, fill_next;

	fes_window #(
		.W(PW),
		.TAPS(PRESSURE_TAPS),
		.TOT_W(PTOT_W),
		.RESET_VAL(int'(fes_pkg::GROUND_RST))
	) u_press_win (
		.clk       (clk),
		.arst_n    (arst_n),
		.shift     (accept && sample.pressure_valid),
		.din       (sample.pressure_pa),
		.load      (ground_load),
		.load_val  (pwdata[PW-1:0]),
		.total_next(ptot_next)
	);

	fes_window #(
		.W(LW),
		.TAPS(LIGHT_TAPS),
		.TOT_W(LTOT_W),
		.RESET_VAL(0)
	) u_light_win (
		.clk       (clk),
		.arst_n    (arst_n),
		.shift     (accept),
		.din       (sample.light_raw),
		.load      (1'b0),
		.load_val  ('0),
		.total_next(ltot_next)
	);

	// light average is over the samples seen so far until the window is full
	assign fill_next = (fill_q == FILL_W'(LIGHT_TAPS)) ? fill_q : fill_q + FILL_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= fill_next;
		end
	end

	logic              pv_s1;
	logic [PTOT_W-1:0] ptot_s1;
	logic [LTOT_W-1:0] ltot_s1;
	logic [FILL_W-1:0] fill_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pv_s1   <= sample.pressure_valid;
			ptot_s1 <= ptot_next;
			ltot_s1 <= ltot_next;
			fill_s1 <= fill_next;
		end
	end

	// stage 2: average by reciprocal multiply, light threshold scaled by fill
	logic [PROD_W-1:0] avg_prod;
	logic [LW:0]       light_lvl;
	logic              pv_s2;
	logic [PW-1:0]     avg_s2;
	logic [LCMP_W-1:0] ltot_s2, thr_s2;

	assign avg_prod  = PROD_W'(ptot_s1) * PROD_W'(RECIP_W'(RECIP));
	assign light_lvl = {1'b0, cfg_q.light_base} + {1'b0, cfg_q.light_margin};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			pv_s2   <= pv_s1;
			avg_s2  <= PW'(avg_prod >> DIV_SH);
			ltot_s2 <= LCMP_W'(ltot_s1);
			thr_s2  <= LCMP_W'(light_lvl) * LCMP_W'(fill_s1);
		end
	end

	// stage 3: event decisions in flight order, result register
	fes_pkg::result_t res_next, result_q;

	fes_events #(
		.STREAK_NEEDED(LIFTOFF_STREAK_NEEDED),
		.LCMP_W(LCMP_W)
	) u_events (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (en3 && v_s2),
		.pv         (pv_s2),
		.avg        (avg_s2),
		.light_total(ltot_s2),
		.light_thr  (thr_s2),
		.cfg        (cfg_q),
		.res        (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (en3) begin
			result_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			result_q <= res_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef ASSERT_OFF
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (v_s1 && v_s2 && result_valid_q && result_stall))
		else $error("tick request stalled with room in the pipeline");

	a_camera_with_nose: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.camera_start) |-> result.nose_cone_seen)
		else $error("camera strobe without nose cone flag");

	a_tether_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.tether_fire) |->
			(result.average_pressure < cfg_q.tether_pressure))
		else $error("tether fired above its pressure");
`endif

endmodule
